// File: sv/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg: shared types and constants for the edge relaxation core
// Holds the request field widths, command codes, controller states and the
// command and status bundles that pass between the controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

  // Fixed field widths of the request and result channels.
  localparam int CMD_W      = 2;
  localparam int VERTEX_W   = 16;
  localparam int WEIGHT_W   = 32;
  localparam int SETV_W     = 32;
  localparam int OUT_DIST_W = 32;
  localparam int COUNT_W    = 17;

  // Default sizing of the distance and flag stores.
  localparam int VERTICES_DEF  = 65536;
  localparam int DIST_BITS_DEF = 32;

  // Command codes. The fourth code behaves as a read that leaves the flag alone.
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELAX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SUM,
    ST_COMMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic fetch;
    logic sum_en;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: sv/spe_ifs.sv
// ----------------------------------------------------------------------------
// spe_ifs: request and result channels of the edge relaxation core
// Valid/ready channels; a request moves at a rising edge where both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface spe_in_if;
  import spe_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [VERTEX_W-1:0] src_vertex;
  logic [VERTEX_W-1:0] dst_vertex;
  logic [WEIGHT_W-1:0] edge_weight;
  logic [SETV_W-1:0]   set_value;

  modport source (
    output valid, command, src_vertex, dst_vertex, edge_weight, set_value,
    input  ready
  );

  modport sink (
    input  valid, command, src_vertex, dst_vertex, edge_weight, set_value,
    output ready
  );
endinterface

interface spe_out_if;
  import spe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OUT_DIST_W-1:0] distance;
  logic                  improved;
  logic                  was_active;
  logic [COUNT_W-1:0]    active_count;

  modport source (
    output valid, distance, improved, was_active, active_count,
    input  ready
  );

  modport sink (
    input  valid, distance, improved, was_active, active_count,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/spe_ctrl.sv
// ----------------------------------------------------------------------------
// spe_ctrl: sequencer of the edge relaxation core
// Runs the flag clearing pass after reset, then steps each request through
// fetch, sum and commit, holding in commit until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire spe_pkg::dp_status_t status,
  output spe_pkg::dp_cmd_t         cmd
);
  import spe_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/spe_dp.sv
// ----------------------------------------------------------------------------
// spe_dp: datapath of the edge relaxation core
// Holds the distance and active flag stores, the saturating adder, the
// compare and update logic, the active counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_dp #(
  parameter int VERTICES  = spe_pkg::VERTICES_DEF,
  parameter int DIST_BITS = spe_pkg::DIST_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire spe_pkg::dp_cmd_t                cmd,
  output spe_pkg::dp_status_t                  status,
  input  wire logic [spe_pkg::CMD_W-1:0]       in_command,
  input  wire logic [spe_pkg::VERTEX_W-1:0]    in_src_vertex,
  input  wire logic [spe_pkg::VERTEX_W-1:0]    in_dst_vertex,
  input  wire logic [spe_pkg::WEIGHT_W-1:0]    in_edge_weight,
  input  wire logic [spe_pkg::SETV_W-1:0]      in_set_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [spe_pkg::OUT_DIST_W-1:0]       out_distance,
  output logic                                 out_improved,
  output logic                                 out_was_active,
  output logic [spe_pkg::COUNT_W-1:0]          out_active_count
);
  import spe_pkg::*;

  localparam int ADDR_W  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int RANGE_W = ((ADDR_W > VERTEX_W) ? ADDR_W : VERTEX_W) + 1;
  localparam int SUM_W   = ((DIST_BITS > WEIGHT_W) ? DIST_BITS : WEIGHT_W) + 1;

  localparam logic [RANGE_W-1:0]   VERT_LIM  = RANGE_W'(VERTICES);
  localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(VERTICES - 1);
  localparam logic [DIST_BITS-1:0] DIST_MAX  = '1;
  localparam logic [SUM_W-1:0]     SUM_MAX   = SUM_W'(DIST_MAX);

  // Captured request.
  logic [CMD_W-1:0]    cmd_r;
  logic [VERTEX_W-1:0] src_r;
  logic [VERTEX_W-1:0] dst_r;
  logic [WEIGHT_W-1:0] wgt_r;
  logic [SETV_W-1:0]   setv_r;

  // Stores and their registered read data.
  logic [DIST_BITS-1:0] dist_mem [VERTICES];
  logic                 flag_mem [VERTICES];
  logic [DIST_BITS-1:0] src_rd_r;
  logic [DIST_BITS-1:0] dst_rd_r;
  logic                 flag_rd_r;

  logic [ADDR_W-1:0]    clr_addr_r;
  logic [ADDR_W-1:0]    clr_addr_nxt;
  logic [DIST_BITS-1:0] sum_r;
  logic [COUNT_W-1:0]   cnt_r;
  logic [COUNT_W-1:0]   cnt_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;

  logic [OUT_DIST_W-1:0] out_dist_r;
  logic                  out_impr_r;
  logic                  out_act_r;

  logic [ADDR_W-1:0]    src_idx;
  logic [ADDR_W-1:0]    dst_idx;
  logic                 src_ok;
  logic                 dst_ok;
  logic [DIST_BITS-1:0] src_dist;
  logic [SUM_W-1:0]     sum_raw;
  logic [DIST_BITS-1:0] sum_sat;
  logic [DIST_BITS-1:0] dst_old;
  logic                 flag_old;
  logic                 is_set;
  logic                 is_relax;
  logic                 is_read;
  logic                 improved;
  logic                 mark;
  logic                 take;
  logic [DIST_BITS-1:0] dist_new;
  logic                 dist_we;
  logic                 flag_we;
  logic [ADDR_W-1:0]    flag_waddr;
  logic                 flag_wdata;

  assign src_idx = ADDR_W'(src_r);
  assign dst_idx = ADDR_W'(dst_r);
  assign src_ok  = RANGE_W'(src_r) < VERT_LIM;
  assign dst_ok  = RANGE_W'(dst_r) < VERT_LIM;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_command;
      src_r  <= in_src_vertex;
      dst_r  <= in_dst_vertex;
      wgt_r  <= in_edge_weight;
      setv_r <= in_set_value;
    end
  end

  // Distance store: two read ports, one write port.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      src_rd_r <= dist_mem[src_idx];
      dst_rd_r <= dist_mem[dst_idx];
    end
    if (dist_we) begin
      dist_mem[dst_idx] <= dist_new;
    end
  end

  // Flag store: shared between the clearing pass and request updates.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      flag_rd_r <= flag_mem[dst_idx];
    end
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
  end

  // Saturating sum; an out of range source counts as unreached.
  assign src_dist = src_ok ? src_rd_r : DIST_MAX;
  assign sum_raw  = SUM_W'(src_dist) + SUM_W'(wgt_r);
  assign sum_sat  = (sum_raw > SUM_MAX) ? DIST_MAX : sum_raw[DIST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      sum_r <= sum_sat;
    end
  end

  // Commit stage.
  assign is_set   = (cmd_r == CMD_SET);
  assign is_relax = (cmd_r == CMD_RELAX);
  assign is_read  = (cmd_r == CMD_READ);
  assign dst_old  = dst_ok ? dst_rd_r : DIST_MAX;
  assign flag_old = dst_ok & flag_rd_r;
  assign improved = is_relax && dst_ok && (sum_r < dst_rd_r);
  assign mark     = improved && !flag_old;
  assign take     = is_read && flag_old;

  always_comb begin
    priority if (is_set && dst_ok) begin
      dist_new = DIST_BITS'(setv_r);
    end else if (improved) begin
      dist_new = sum_r;
    end else begin
      dist_new = dst_old;
    end
  end

  assign dist_we    = cmd.commit && dst_ok && (is_set || improved);
  assign flag_we    = cmd.clear_step || (cmd.commit && (mark || take));
  assign flag_waddr = cmd.clear_step ? clr_addr_r : dst_idx;
  assign flag_wdata = cmd.clear_step ? 1'b0 : mark;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.commit) begin
      priority if (mark) begin
        cnt_nxt = cnt_r + COUNT_W'(1);
      end else if (take) begin
        cnt_nxt = cnt_r - COUNT_W'(1);
      end else begin
        cnt_nxt = cnt_r;
      end
    end
  end

  assign clr_addr_nxt  = cmd.clear_step ? clr_addr_r + ADDR_W'(1) : clr_addr_r;
  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_addr_r  <= clr_addr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_dist_r <= OUT_DIST_W'(dist_new);
      out_impr_r <= improved;
      out_act_r  <= flag_old;
    end
  end

  assign status.clear_last = (clr_addr_r == LAST_ADDR);
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_distance     = out_dist_r;
  assign out_improved     = out_impr_r;
  assign out_was_active   = out_act_r;
  assign out_active_count = cnt_r;

endmodule

`default_nettype wire

// File: sv/shortest_path_edge_relaxation_core.sv
// ----------------------------------------------------------------------------
// shortest_path_edge_relaxation_core: frontier shortest path relaxation engine
// Per-vertex distance store and next-active flags with set, relax and read
// requests, one result per request.
// ----------------------------------------------------------------------------
// Each request steps through the accept state, the registered read of
// the distance and flag stores, the saturating add of source distance and
// edge weight, and the compare, the store write-back and the loading of the
// result register. The result register lets the core take the next request
// while the previous result still waits; a request only stalls in its last
// step while the result register is still full. After reset the core sweeps
// the active flag store, one entry per cycle, and accepts no request until
// the sweep has cleared every entry of that store.
// Distances are undefined until written by a set request, so every vertex
// that is later relaxed from or read must first be set; an all ones distance
// means unreached and never improves a neighbor. Vertices at or beyond
// VERTICES read as unreached with a clear flag and are never written.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_path_edge_relaxation_core #(
  parameter int VERTICES  = spe_pkg::VERTICES_DEF,
  parameter int DIST_BITS = spe_pkg::DIST_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spe_in_if.sink    in_ch,
  spe_out_if.source out_ch
);
  import spe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // The controller sequences each request; the datapath owns all storage.
  spe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  spe_dp #(
    .VERTICES  (VERTICES),
    .DIST_BITS (DIST_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_command       (in_ch.command),
    .in_src_vertex    (in_ch.src_vertex),
    .in_dst_vertex    (in_ch.dst_vertex),
    .in_edge_weight   (in_ch.edge_weight),
    .in_set_value     (in_ch.set_value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_distance     (out_ch.distance),
    .out_improved     (out_ch.improved),
    .out_was_active   (out_ch.was_active),
    .out_active_count (out_ch.active_count)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

// File: tb/sv/tb_shortest_path_edge_relaxation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_path_edge_relaxation_core: self-checking bench for the core
// Drives set, relax, read and unused-code requests through the request
// channel, mirrors the distance store, the active flags and their count in a
// behavioral predictor, and compares every result field by field. A short
// table of directed requests comes first, then randomized shortest path
// episodes on small random subgraphs with some noise mixed in. Both sides of
// the core idle at random while this runs.
// ----------------------------------------------------------------------------

module tb_shortest_path_edge_relaxation_core;
  import spe_pkg::*;

  // The package has no name for the fourth command code. The core answers it
  // like a read that leaves the active flag alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [OUT_DIST_W-1:0] UNREACHED = '1;

  localparam int DIR_ROWS     = 25;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_PRINTED  = 40;

  // The budget first covers the sweep of the flag store after reset. The rest
  // of the budget covers about 750 requests, each of them meeting the longest
  // sender gap and the longest result stall, taken many times over.
  localparam int CYCLE_LIMIT = VERTICES_DEF + 400_000;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [VERTEX_W-1:0] src_vertex;
    logic [VERTEX_W-1:0] dst_vertex;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [SETV_W-1:0]   set_value;
  } request_t;

  typedef struct packed {
    logic [OUT_DIST_W-1:0] distance;
    logic                  improved;
    logic                  was_active;
    logic [COUNT_W-1:0]    active_count;
  } result_t;

  // One row of the directed table. Where typed is set, the expected result is
  // written out in the row itself; otherwise the predictor supplies it.
  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [VERTEX_W-1:0]   src_vertex;
    logic [VERTEX_W-1:0]   dst_vertex;
    logic [WEIGHT_W-1:0]   edge_weight;
    logic [SETV_W-1:0]     set_value;
    logic                  typed;
    logic [OUT_DIST_W-1:0] exp_distance;
    logic                  exp_improved;
    logic                  exp_was_active;
    logic [COUNT_W-1:0]    exp_count;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  spe_in_if  req_ch ();
  spe_out_if res_ch ();

  shortest_path_edge_relaxation_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  // Mirror of the core state. Distances live in an associative array, so an
  // entry that exists is exactly an entry that a set request has written.
  logic [OUT_DIST_W-1:0] distance_mirror [int unsigned];
  bit                    flag_mirror [VERTICES_DEF];
  logic [COUNT_W-1:0]    frontier_size;
  logic [VERTEX_W-1:0]   written_vertices [$];

  result_t pending_results [$];

  int unsigned burst_left      = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned lowered_seen    = 0;
  int unsigned flags_taken     = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;

  // The directed table. It walks the saturating add (unreached source, all
  // ones weight, a sum that overflows, a sum that lands exactly on all ones),
  // a self loop, a set on a vertex whose flag is up, both read flavors and
  // the vertex and value extremes. The last rows are left to the predictor.
  directed_row_t directed_rows [DIR_ROWS] = '{
    '{CMD_SET,    16'h0000, 16'h0000, 32'h0,        32'h0,        1'b1,
      32'h0,        1'b0, 1'b0, 17'd0},
    '{CMD_SET,    16'h0000, 16'hFFFF, 32'h0,        32'hFFFFFFFF, 1'b1,
      32'hFFFFFFFF, 1'b0, 1'b0, 17'd0},
    '{CMD_SET,    16'h0000, 16'h0001, 32'h0,        32'h64,       1'b1,
      32'h64,       1'b0, 1'b0, 17'd0},
    '{CMD_SET,    16'h0000, 16'h0002, 32'h0,        32'hFFFFFFFF, 1'b1,
      32'hFFFFFFFF, 1'b0, 1'b0, 17'd0},
    '{CMD_RELAX,  16'h0000, 16'h0001, 32'h0,        32'h0,        1'b1,
      32'h0,        1'b1, 1'b0, 17'd1},
    '{CMD_RELAX,  16'hFFFF, 16'h0002, 32'h0,        32'h0,        1'b1,
      32'hFFFFFFFF, 1'b0, 1'b0, 17'd1},
    '{CMD_RELAX,  16'h0001, 16'h0002, 32'hFFFFFFFF, 32'h0,        1'b1,
      32'hFFFFFFFF, 1'b0, 1'b0, 17'd1},
    '{CMD_SET,    16'h0000, 16'h0003, 32'h0,        32'h5,        1'b1,
      32'h5,        1'b0, 1'b0, 17'd1},
    '{CMD_RELAX,  16'h0003, 16'h0002, 32'hFFFFFFFE, 32'h0,        1'b1,
      32'hFFFFFFFF, 1'b0, 1'b0, 17'd1},
    '{CMD_RELAX,  16'h0003, 16'h0002, 32'h7,        32'h0,        1'b1,
      32'hC,        1'b1, 1'b0, 17'd2},
    '{CMD_RELAX,  16'h0000, 16'h0002, 32'h3,        32'h0,        1'b1,
      32'h3,        1'b1, 1'b1, 17'd2},
    '{CMD_READ,   16'h0000, 16'h0002, 32'h0,        32'h0,        1'b1,
      32'h3,        1'b0, 1'b1, 17'd1},
    '{CMD_READ,   16'h0000, 16'h0002, 32'h0,        32'h0,        1'b1,
      32'h3,        1'b0, 1'b0, 17'd1},
    '{CMD_UNUSED, 16'h0000, 16'h0001, 32'h0,        32'h0,        1'b1,
      32'h0,        1'b0, 1'b1, 17'd1},
    '{CMD_READ,   16'h0000, 16'h0001, 32'h0,        32'h0,        1'b1,
      32'h0,        1'b0, 1'b1, 17'd0},
    '{CMD_RELAX,  16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'h0,        1'b1,
      32'hFFFFFFFF, 1'b0, 1'b0, 17'd0},
    '{CMD_SET,    16'h0000, 16'hFFFF, 32'h0,        32'h0,        1'b1,
      32'h0,        1'b0, 1'b0, 17'd0},
    '{CMD_RELAX,  16'h0000, 16'h0000, 32'h0,        32'h0,        1'b1,
      32'h0,        1'b0, 1'b0, 17'd0},
    '{CMD_SET,    16'h0000, 16'h8000, 32'h0,        32'hFFFFFFFF, 1'b1,
      32'hFFFFFFFF, 1'b0, 1'b0, 17'd0},
    '{CMD_RELAX,  16'hFFFF, 16'h8000, 32'hFFFFFFFF, 32'h0,        1'b1,
      32'hFFFFFFFF, 1'b0, 1'b0, 17'd0},
    '{CMD_RELAX,  16'hFFFF, 16'h8000, 32'hFFFFFFFE, 32'h0,        1'b1,
      32'hFFFFFFFE, 1'b1, 1'b0, 17'd1},
    '{CMD_SET,    16'h0000, 16'h8000, 32'h0,        32'h5,        1'b1,
      32'h5,        1'b0, 1'b1, 17'd1},
    '{CMD_READ,   16'h0000, 16'h8000, 32'h0,        32'h0,        1'b1,
      32'h5,        1'b0, 1'b1, 17'd0},
    '{CMD_SET,    16'h0000, 16'h5555, 32'h0,        32'hAAAAAAAA, 1'b0,
      32'h0,        1'b0, 1'b0, 17'd0},
    '{CMD_RELAX,  16'h5555, 16'h0003, 32'h12345678, 32'h0,        1'b0,
      32'h0,        1'b0, 1'b0, 17'd0}
  };

  // Distance as the core reports it: vertices past the end of the store read
  // as unreached.
  function automatic logic [OUT_DIST_W-1:0] stored_distance(input logic [VERTEX_W-1:0] v);
    if (v >= VERTICES_DEF) begin
      return UNREACHED;
    end
    return distance_mirror[v];
  endfunction

  // Predictor: applies one request to the mirror and returns the result the
  // core must produce for it.
  task automatic predict_relaxation(input request_t r, output result_t res);
    logic [OUT_DIST_W-1:0] src_dist;
    logic [OUT_DIST_W:0]   wide_sum;
    logic [OUT_DIST_W-1:0] candidate;
    logic                  dst_ok;
    dst_ok         = r.dst_vertex < VERTICES_DEF;
    res.was_active = dst_ok && flag_mirror[r.dst_vertex];
    res.improved   = 1'b0;
    case (r.command)
      CMD_SET: begin
        if (dst_ok) begin
          if (!distance_mirror.exists(r.dst_vertex)) begin
            written_vertices.push_back(r.dst_vertex);
          end
          distance_mirror[r.dst_vertex] = r.set_value;
        end
      end
      CMD_RELAX: begin
        // A carry out of the add means the path is no better than unreached.
        src_dist  = stored_distance(r.src_vertex);
        wide_sum  = {1'b0, src_dist} + {1'b0, r.edge_weight};
        candidate = wide_sum[OUT_DIST_W] ? UNREACHED : wide_sum[OUT_DIST_W-1:0];
        if (dst_ok && candidate < distance_mirror[r.dst_vertex]) begin
          distance_mirror[r.dst_vertex] = candidate;
          if (!flag_mirror[r.dst_vertex]) begin
            flag_mirror[r.dst_vertex] = 1'b1;
            frontier_size++;
          end
          res.improved = 1'b1;
        end
      end
      CMD_READ: begin
        if (dst_ok && flag_mirror[r.dst_vertex]) begin
          flag_mirror[r.dst_vertex] = 1'b0;
          frontier_size--;
        end
      end
      default: begin
        // The unused code only reports; nothing changes.
      end
    endcase
    res.distance     = stored_distance(r.dst_vertex);
    res.active_count = frontier_size;
  endtask

  // Builds a request and fills the fields that its command ignores with
  // random bits, so those inputs toggle too.
  function automatic request_t make_request(input logic [CMD_W-1:0] cmd,
                                            input logic [VERTEX_W-1:0] src,
                                            input logic [VERTEX_W-1:0] dst,
                                            input logic [WEIGHT_W-1:0] weight,
                                            input logic [SETV_W-1:0] setv);
    request_t r;
    r.command     = cmd;
    r.src_vertex  = (cmd == CMD_RELAX) ? src : VERTEX_W'($urandom);
    r.dst_vertex  = dst;
    r.edge_weight = (cmd == CMD_RELAX) ? weight : $urandom;
    r.set_value   = (cmd == CMD_SET) ? setv : $urandom;
    return r;
  endfunction

  function automatic logic [VERTEX_W-1:0] pick_written();
    return written_vertices[$urandom_range(0, written_vertices.size() - 1)];
  endfunction

  // Mostly short edges so that paths keep improving, with a few huge weights
  // that push the add into saturation.
  function automatic logic [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return UNREACHED - $urandom_range(0, 3);
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  // Sender. It works in bursts: after a burst of random length it may drop
  // valid for a random gap. Valid stays high from one request to the next
  // inside a burst, so it is never lowered and raised in the same step.
  task automatic send_request(input request_t r, input bit use_typed,
                              input result_t typed_res);
    result_t     predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= r.command;
    req_ch.src_vertex  <= r.src_vertex;
    req_ch.dst_vertex  <= r.dst_vertex;
    req_ch.edge_weight <= r.edge_weight;
    req_ch.set_value   <= r.set_value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    requests_sent++;
    predict_relaxation(r, predicted);
    pending_results.push_back(use_typed ? typed_res : predicted);
  endtask

  // Sender pause until the core has handed back every result.
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Noise between the well-formed traffic: stray sets, unused codes, reads
  // and relaxations between any vertices written so far.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_request(make_request(CMD_SET, 0, VERTEX_W'($urandom),
                                   0, ($urandom_range(0, 3) == 0) ? UNREACHED : $urandom),
                      1'b0, '0);
      1: send_request(make_request(CMD_UNUSED, 0, pick_written(), 0, 0), 1'b0, '0);
      2: send_request(make_request(CMD_READ, 0, pick_written(), 0, 0), 1'b0, '0);
      default: send_request(make_request(CMD_RELAX, pick_written(), pick_written(),
                                         random_weight(), 0), 1'b0, '0);
    endcase
  endtask

  // One shortest path episode on a small random subgraph: initialize every
  // vertex, then a few rounds of edge relaxations, each round ending with a
  // read of every vertex that takes the frontier flags, as a frontier based
  // solver would.
  task automatic run_episode();
    logic [VERTEX_W-1:0] nodes [$];
    int unsigned         n;
    int unsigned         pick;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 24) : $urandom_range(3, 10);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        nodes.push_back(pick_written());
      end else begin
        nodes.push_back(VERTEX_W'($urandom));
      end
    end
    // The first vertex is the source with a small start distance; the rest
    // start unreached, now and then at an arbitrary value.
    foreach (nodes[i]) begin
      send_request(make_request(CMD_SET, 0, nodes[i], 0,
                                (i == 0) ? SETV_W'($urandom_range(0, 50)) :
                                ($urandom_range(0, 7) == 0) ? $urandom : UNREACHED),
                   1'b0, '0);
    end
    repeat ($urandom_range(2, 5)) begin
      repeat (n * $urandom_range(1, 3)) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          send_request(make_request(CMD_RELAX, nodes[$urandom_range(0, n - 1)],
                                    nodes[$urandom_range(0, n - 1)], random_weight(), 0),
                       1'b0, '0);
        end else if (pick < 16) begin
          send_request(make_request(CMD_READ, 0, nodes[$urandom_range(0, n - 1)], 0, 0),
                       1'b0, '0);
        end else begin
          send_noise();
        end
      end
      foreach (nodes[i]) begin
        send_request(make_request(CMD_READ, 0, nodes[i], 0, 0), 1'b0, '0);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      hold_until_drained();
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  // Receiver. It switches between stall styles on segments of random length:
  // always ready, mostly ready, mostly stalled, and runs of back pressure.
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_run  = 0;
  logic        ready_next;
  result_t     oldest;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 150);
    end
    mode_left--;
    case (stall_mode)
      0: ready_next = 1'b1;
      1: ready_next = ($urandom_range(0, 3) != 0);
      2: ready_next = ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          ready_next = 1'b0;
        end else begin
          ready_next = 1'b1;
          stall_run  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        end
      end
    endcase
    res_ch.ready <= ready_next;

    // Checker: every accepted result is matched against the oldest request
    // still waiting for its answer.
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (res_ch.distance !== oldest.distance) begin
          report_mismatch($sformatf("distance got %h expected %h",
                                    res_ch.distance, oldest.distance));
        end
        if (res_ch.improved !== oldest.improved) begin
          report_mismatch($sformatf("improved got %b expected %b",
                                    res_ch.improved, oldest.improved));
        end
        if (res_ch.was_active !== oldest.was_active) begin
          report_mismatch($sformatf("was_active got %b expected %b",
                                    res_ch.was_active, oldest.was_active));
        end
        if (res_ch.active_count !== oldest.active_count) begin
          report_mismatch($sformatf("active_count got %0d expected %0d",
                                    res_ch.active_count, oldest.active_count));
        end
        if (oldest.improved) begin
          lowered_seen++;
        end
        if (oldest.was_active && res_ch.was_active === 1'b1) begin
          flags_taken++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    directed_row_t row;
    result_t       typed_res;
    rst_n              = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_SET;
    req_ch.src_vertex  = '0;
    req_ch.dst_vertex  = '0;
    req_ch.edge_weight = '0;
    req_ch.set_value   = '0;
    res_ch.ready       = 1'b0;
    frontier_size      = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The core is still sweeping its flag store at this
    // point, so the first request simply waits for ready.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row                    = directed_rows[i];
      typed_res.distance     = row.exp_distance;
      typed_res.improved     = row.exp_improved;
      typed_res.was_active   = row.exp_was_active;
      typed_res.active_count = row.exp_count;
      send_request('{row.command, row.src_vertex, row.dst_vertex,
                     row.edge_weight, row.set_value},
                   row.typed, typed_res);
    end
    hold_until_drained();

    // Random part: episodes until enough requests have gone in.
    while (requests_sent < DIR_ROWS + RANDOM_ITEMS) begin
      run_episode();
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results still outstanding at the end of the run");
    end

    $display("Covered %0d requests (%0d directed), %0d results checked,",
             requests_sent, DIR_ROWS, results_checked);
    $display("%0d relaxations lowered a distance, %0d results reported a raised flag.",
             lowered_seen, flags_taken);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
